// ----- hw/rtl/qs_pkg.sv -----
// Shared constants, word types, state codes and control bundles for the quicksort sorter.
`default_nettype none
package qs_pkg;

	localparam int MAX_ITEMS = 32;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last_in;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     last_out;
		logic                     overflow;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT_INIT,
		ST_POP,
		ST_PIV_RD,
		ST_PIV_LD,
		ST_SCAN_I,
		ST_SCAN_J,
		ST_SWAP1,
		ST_SWAP2,
		ST_FIN1,
		ST_FIN2,
		ST_PUSH_R,
		ST_OUT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		RD_LO,
		RD_I,
		RD_I_NEXT,
		RD_J,
		RD_J_PREV,
		RD_K
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_I_VJ,
		WR_J_VI,
		WR_LO_VJ,
		WR_J_PV
	} wr_sel_t;

	typedef struct packed {
		logic    load;
		logic    clr;
		logic    push_init;
		logic    pop;
		logic    pv_ld;
		logic    i_inc;
		logic    j_dec;
		logic    vi_ld;
		logic    vj_ld;
		logic    push_left;
		logic    push_right;
		logic    k_inc;
		logic    emit;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
	} cmd_t;

	typedef struct packed {
		logic cnt_lt2;
		logic stack_empty;
		logic i_go;
		logic j_go;
		logic i_ge_j;
		logic k_last;
	} sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/quicksort_sorter.sv -----
// Top level of the quicksort sorter: controller and datapath.
// Load: one word per cycle while busy is low; the word with last_in starts the sort.
// Sort: a setup step, then each range popped from the stack is partitioned; all element reads
//   go through the single read port of the element store.
// Output: n result words on consecutive cycles, the first in the cycle after output begins;
//   busy drops right after the final word. Results cannot be stalled.
// Reset clears control, counts and flags; store contents stay.
`default_nettype none
module quicksort_sorter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire qs_pkg::in_word_t  item,
	output logic                   busy,
	output qs_pkg::out_word_t      result,
	output logic                   result_vld
);

	qs_pkg::cmd_t cmd;
	qs_pkg::sts_t sts;

	// sequence the work
	qs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// hold data and indices
	qs_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cmd        (cmd),
		.sts        (sts),
		.result     (result),
		.result_vld (result_vld)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/qs_datapath.sv -----
// Element store, range stack, scan indices and result register of the quicksort sorter.
`default_nettype none
module qs_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire qs_pkg::in_word_t item,
	input  wire qs_pkg::cmd_t     cmd,
	output qs_pkg::sts_t          sts,
	output qs_pkg::out_word_t     result,
	output logic                  result_vld
);

	localparam int IDX_W = qs_pkg::IDX_W;
	localparam int CNT_W = qs_pkg::CNT_W;

	logic signed [qs_pkg::DATA_W-1:0] mem_q [qs_pkg::MAX_ITEMS];
	logic [IDX_W-1:0]                 stk_lo_q [qs_pkg::MAX_ITEMS];
	logic [IDX_W-1:0]                 stk_hi_q [qs_pkg::MAX_ITEMS];

	logic [CNT_W-1:0]                 count_q, sp_q, i_q, k_q;
	logic                             drop_q;
	logic [IDX_W-1:0]                 lo_q, hi_q, j_q;
	logic signed [qs_pkg::DATA_W-1:0] pv_q, vi_q, vj_q, rdata_q;
	logic                             emit_s1, last_s1;

	logic [IDX_W-1:0]                 raddr, waddr, top_idx;
	logic signed [qs_pkg::DATA_W-1:0] wdata;
	logic                             we, full;
	logic [CNT_W-1:0]                 i_nxt, j_ext, lo_ext, hi_ext;
	logic                             push_l_ok, push_r_ok;

	assign full    = (count_q == CNT_W'(qs_pkg::MAX_ITEMS));
	assign i_nxt   = i_q + CNT_W'(1);
	assign j_ext   = CNT_W'(j_q);
	assign lo_ext  = CNT_W'(lo_q);
	assign hi_ext  = CNT_W'(hi_q);
	assign top_idx = IDX_W'(sp_q - CNT_W'(1));

	// left part needs two or more elements, right part likewise
	assign push_l_ok = (j_ext > lo_ext + CNT_W'(1)) && (sp_q < CNT_W'(qs_pkg::MAX_ITEMS));
	assign push_r_ok = (j_ext + CNT_W'(1) < hi_ext) && (sp_q < CNT_W'(qs_pkg::MAX_ITEMS));

	// status toward the controller
	always_comb begin
		sts.cnt_lt2     = (count_q < CNT_W'(2));
		sts.stack_empty = (sp_q == '0);
		sts.i_go        = (i_q <= hi_ext) && (rdata_q <= pv_q);
		sts.j_go        = (j_q > lo_q) && (rdata_q > pv_q);
		sts.i_ge_j      = (i_q >= j_ext);
		sts.k_last      = (k_q == count_q - CNT_W'(1));
	end

	// select the store read address
	always_comb begin
		unique case (cmd.rd_sel)
			qs_pkg::RD_LO:     raddr = lo_q;
			qs_pkg::RD_I:      raddr = i_q[IDX_W-1:0];
			qs_pkg::RD_I_NEXT: raddr = i_nxt[IDX_W-1:0];
			qs_pkg::RD_J:      raddr = j_q;
			qs_pkg::RD_J_PREV: raddr = j_q - IDX_W'(1);
			qs_pkg::RD_K:      raddr = k_q[IDX_W-1:0];
			default:           raddr = lo_q;
		endcase
	end

	// select the store write port: loading or swapping
	always_comb begin
		we    = 1'b0;
		waddr = count_q[IDX_W-1:0];
		wdata = item.value;
		unique case (cmd.wr_sel)
			qs_pkg::WR_I_VJ: begin
				we    = 1'b1;
				waddr = i_q[IDX_W-1:0];
				wdata = vj_q;
			end
			qs_pkg::WR_J_VI: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = vi_q;
			end
			qs_pkg::WR_LO_VJ: begin
				we    = 1'b1;
				waddr = lo_q;
				wdata = vj_q;
			end
			qs_pkg::WR_J_PV: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = pv_q;
			end
			default: begin
				we = cmd.load && !full;
			end
		endcase
	end

	// element store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	// range stack entries
	always_ff @(posedge clk) begin
		if (cmd.push_init) begin
			stk_lo_q[0] <= '0;
			stk_hi_q[0] <= IDX_W'(count_q - CNT_W'(1));
		end else if (cmd.push_left && push_l_ok) begin
			stk_lo_q[sp_q[IDX_W-1:0]] <= lo_q;
			stk_hi_q[sp_q[IDX_W-1:0]] <= j_q - IDX_W'(1);
		end else if (cmd.push_right && push_r_ok) begin
			stk_lo_q[sp_q[IDX_W-1:0]] <= j_q + IDX_W'(1);
			stk_hi_q[sp_q[IDX_W-1:0]] <= hi_q;
		end
	end

	// count, drop flag, stack depth and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
			sp_q    <= '0;
			emit_s1 <= 1'b0;
		end else begin
			emit_s1 <= cmd.emit;
			if (cmd.clr) begin
				count_q <= '0;
				drop_q  <= 1'b0;
				sp_q    <= '0;
			end else begin
				if (cmd.load) begin
					if (full) begin
						drop_q <= 1'b1;
					end else begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				if (cmd.push_init) begin
					sp_q <= CNT_W'(1);
				end else if (cmd.pop) begin
					sp_q <= sp_q - CNT_W'(1);
				end else if ((cmd.push_left && push_l_ok) || (cmd.push_right && push_r_ok)) begin
					sp_q <= sp_q + CNT_W'(1);
				end
			end
		end
	end

	// partition indices, pivot and scan words
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			lo_q <= stk_lo_q[top_idx];
			hi_q <= stk_hi_q[top_idx];
			i_q  <= CNT_W'(stk_lo_q[top_idx]);
			j_q  <= stk_hi_q[top_idx];
		end else begin
			if (cmd.i_inc) begin
				i_q <= i_nxt;
			end
			if (cmd.j_dec) begin
				j_q <= j_q - IDX_W'(1);
			end
		end
		if (cmd.pv_ld) begin
			pv_q <= rdata_q;
		end
		if (cmd.vi_ld) begin
			vi_q <= rdata_q;
		end
		if (cmd.vj_ld) begin
			vj_q <= rdata_q;
		end
		// rewind the output index on clear, on stack init and whenever a set is being loaded
		if (cmd.clr || cmd.push_init || cmd.load) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + CNT_W'(1);
		end
		last_s1 <= sts.k_last;
	end

	// drive the result word
	assign result_vld          = emit_s1;
	assign result.sorted_value = rdata_q;
	assign result.last_out     = last_s1;
	assign result.overflow     = drop_q;

`ifndef SYNTHESIS
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CNT_W'(qs_pkg::MAX_ITEMS / 2))
		else $error("range stack deeper than half the store");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(qs_pkg::MAX_ITEMS))
		else $error("element count beyond capacity");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit_s1 && last_s1 |=> !emit_s1)
		else $error("result strobe continues after the final word");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.i_inc |-> i_q <= hi_ext)
		else $error("left scan advanced past the upper bound");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/qs_ctrl.sv -----
// Sequencing state machine of the quicksort sorter: load, partition, stack and output.
`default_nettype none
module qs_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire qs_pkg::in_word_t item,
	input  wire qs_pkg::sts_t     sts,
	output qs_pkg::cmd_t          cmd,
	output logic                  busy
);

	qs_pkg::state_t state_q, state_nxt;

	// hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// advance the sequence
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			qs_pkg::ST_IDLE:      if (start && item.last_in) state_nxt = qs_pkg::ST_SORT_INIT;
			qs_pkg::ST_SORT_INIT: state_nxt = sts.cnt_lt2 ? qs_pkg::ST_OUT : qs_pkg::ST_POP;
			qs_pkg::ST_POP:       state_nxt = sts.stack_empty ? qs_pkg::ST_OUT : qs_pkg::ST_PIV_RD;
			qs_pkg::ST_PIV_RD:    state_nxt = qs_pkg::ST_PIV_LD;
			qs_pkg::ST_PIV_LD:    state_nxt = qs_pkg::ST_SCAN_I;
			qs_pkg::ST_SCAN_I:    if (!sts.i_go) state_nxt = qs_pkg::ST_SCAN_J;
			qs_pkg::ST_SCAN_J: begin
				if (!sts.j_go) begin
					state_nxt = sts.i_ge_j ? qs_pkg::ST_FIN1 : qs_pkg::ST_SWAP1;
				end
			end
			qs_pkg::ST_SWAP1:     state_nxt = qs_pkg::ST_SWAP2;
			qs_pkg::ST_SWAP2:     state_nxt = qs_pkg::ST_SCAN_I;
			qs_pkg::ST_FIN1:      state_nxt = qs_pkg::ST_FIN2;
			qs_pkg::ST_FIN2:      state_nxt = qs_pkg::ST_PUSH_R;
			qs_pkg::ST_PUSH_R:    state_nxt = qs_pkg::ST_POP;
			qs_pkg::ST_OUT:       if (sts.k_last) state_nxt = qs_pkg::ST_DONE;
			qs_pkg::ST_DONE:      state_nxt = qs_pkg::ST_IDLE;
			default:              state_nxt = qs_pkg::ST_IDLE;
		endcase
	end

	// decode datapath commands
	always_comb begin
		cmd        = '0;
		cmd.rd_sel = qs_pkg::RD_LO;
		cmd.wr_sel = qs_pkg::WR_NONE;
		unique case (state_q)
			qs_pkg::ST_IDLE:      cmd.load = start;
			qs_pkg::ST_SORT_INIT: cmd.push_init = !sts.cnt_lt2;
			qs_pkg::ST_POP:       cmd.pop = !sts.stack_empty;
			qs_pkg::ST_PIV_RD:    cmd.rd_sel = qs_pkg::RD_LO;
			qs_pkg::ST_PIV_LD: begin
				cmd.pv_ld  = 1'b1;
				cmd.rd_sel = qs_pkg::RD_I;
			end
			qs_pkg::ST_SCAN_I: begin
				if (sts.i_go) begin
					cmd.i_inc  = 1'b1;
					cmd.rd_sel = qs_pkg::RD_I_NEXT;
				end else begin
					cmd.vi_ld  = 1'b1;
					cmd.rd_sel = qs_pkg::RD_J;
				end
			end
			qs_pkg::ST_SCAN_J: begin
				if (sts.j_go) begin
					cmd.j_dec  = 1'b1;
					cmd.rd_sel = qs_pkg::RD_J_PREV;
				end else begin
					cmd.vj_ld = 1'b1;
				end
			end
			qs_pkg::ST_SWAP1:     cmd.wr_sel = qs_pkg::WR_I_VJ;
			qs_pkg::ST_SWAP2: begin
				cmd.wr_sel = qs_pkg::WR_J_VI;
				cmd.rd_sel = qs_pkg::RD_I;
			end
			qs_pkg::ST_FIN1:      cmd.wr_sel = qs_pkg::WR_LO_VJ;
			qs_pkg::ST_FIN2: begin
				cmd.wr_sel    = qs_pkg::WR_J_PV;
				cmd.push_left = 1'b1;
			end
			qs_pkg::ST_PUSH_R:    cmd.push_right = 1'b1;
			qs_pkg::ST_OUT: begin
				cmd.rd_sel = qs_pkg::RD_K;
				cmd.k_inc  = 1'b1;
				cmd.emit   = 1'b1;
			end
			qs_pkg::ST_DONE:      cmd.clr = 1'b1;
			default:              cmd.clr = 1'b0;
		endcase
	end

	assign busy = (state_q != qs_pkg::ST_IDLE);

endmodule
`default_nettype wire
